// File: design/rlph_pkg.sv
// shared types, codes and reset constants for the radio link pairing and hop controller
`timescale 1ns / 1ps

package rlph_pkg;

  // field widths
  localparam int ID_W       = 24;
  localparam int SET_W      = 32;
  localparam int CH_W       = 8;
  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // default number of hop channels
  localparam int HOP_CHANNELS_DEF = 4;

  // register reset values
  localparam logic [SET_W-1:0]  DEFAULT_CHANNELS_RST = 32'd1178482222;
  localparam logic [ID_W-1:0]   KNOWN_ID_RST         = 24'd335967;
  localparam logic [SET_W-1:0]  KNOWN_CHANNELS_RST   = 32'd1296383285;
  localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST    = 16'd1000;

  // input command codes
  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEFAULT_CHANNELS = 2'd0,
    CFG_KNOWN_ID         = 2'd1,
    CFG_KNOWN_CHANNELS   = 2'd2,
    CFG_TIMEOUT_TICKS    = 2'd3
  } cfg_reg_t;

  // link state
  typedef enum logic [1:0] {
    LINK_REINIT = 2'd0,
    LINK_PAIR   = 2'd1,
    LINK_BIND   = 2'd2
  } link_mode_t;

  // configuration bundle from the register file to the step logic
  typedef struct packed {
    logic [SET_W-1:0]  default_channels;
    logic [ID_W-1:0]   known_id;
    logic [SET_W-1:0]  known_channels;
    logic [TICK_W-1:0] timeout_ticks;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic            hop;
    logic [CH_W-1:0] channel;
    logic            disconnected;
    logic [1:0]      link_state;
  } result_t;

endpackage

// File: design/rlph_in_if.sv
// input channel interface: packet or tick items
`timescale 1ns / 1ps

interface rlph_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic                      pair_flag;
  logic [rlph_pkg::ID_W-1:0] transmitter_id;

  modport source (output valid, output command, output pair_flag, output transmitter_id,
                  input ready);
  modport sink   (input valid, input command, input pair_flag, input transmitter_id,
                  output ready);
endinterface

// File: design/rlph_out_if.sv
// result channel interface: hop orders and link status
`timescale 1ns / 1ps

interface rlph_out_if;
  logic                      valid;
  logic                      ready;
  logic                      hop;
  logic [rlph_pkg::CH_W-1:0] channel;
  logic                      disconnected;
  logic [1:0]                link_state;

  modport source (output valid, output hop, output channel, output disconnected,
                  output link_state, input ready);
  modport sink   (input valid, input hop, input channel, input disconnected,
                  input link_state, output ready);
endinterface

// File: design/rlph_cfg_if.sv
// configuration write channel interface
`timescale 1ns / 1ps

interface rlph_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rlph_pkg::CFG_IDX_W-1:0]  index;
  logic [rlph_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/rlph_cfg_regs.sv
// configuration register file
`timescale 1ns / 1ps

module rlph_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  rlph_cfg_if.sink        cfg_ch,
  output rlph_pkg::cfg_t  cfg
);

  rlph_pkg::cfg_t cfg_r;

  // always able to take a write
  assign cfg_ch.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.default_channels <= rlph_pkg::DEFAULT_CHANNELS_RST;
      cfg_r.known_id         <= rlph_pkg::KNOWN_ID_RST;
      cfg_r.known_channels   <= rlph_pkg::KNOWN_CHANNELS_RST;
      cfg_r.timeout_ticks    <= rlph_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        rlph_pkg::CFG_DEFAULT_CHANNELS: begin
          cfg_r.default_channels <= cfg_ch.data[rlph_pkg::SET_W-1:0];
        end
        rlph_pkg::CFG_KNOWN_ID: begin
          cfg_r.known_id <= cfg_ch.data[rlph_pkg::ID_W-1:0];
        end
        rlph_pkg::CFG_KNOWN_CHANNELS: begin
          cfg_r.known_channels <= cfg_ch.data[rlph_pkg::SET_W-1:0];
        end
        rlph_pkg::CFG_TIMEOUT_TICKS: begin
          cfg_r.timeout_ticks <= cfg_ch.data[rlph_pkg::TICK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/rlph_step.sv
// link state machine, hop counter and tick counter for one item per cycle while step_en is high
`timescale 1ns / 1ps

module rlph_step #(
  parameter int HOP_CHANNELS = rlph_pkg::HOP_CHANNELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_en,
  input  logic                      command,
  input  logic                      pair_flag,
  input  logic [rlph_pkg::ID_W-1:0] transmitter_id,
  input  rlph_pkg::cfg_t            cfg,
  output rlph_pkg::result_t         res
);

  localparam int PERIOD = 2 * HOP_CHANNELS;
  localparam int POS_W  = $clog2(PERIOD);

  rlph_pkg::link_mode_t          mode_r, mode_nxt;
  logic [POS_W-1:0]              hop_pos_r, hop_pos_nxt;
  logic                          known_r, known_nxt;
  logic [rlph_pkg::TICK_W-1:0]   ticks_r, ticks_nxt;

  logic [POS_W:0]                hop_inc;
  logic [rlph_pkg::TICK_W:0]     tick_inc;
  logic                          is_packet;
  logic                          timeout;
  logic [POS_W-1:0]              half_pos;
  logic [1:0]                    slot;
  logic [rlph_pkg::SET_W-1:0]    chan_set;

  assign is_packet = (command == rlph_pkg::CMD_PACKET);
  assign hop_inc   = {1'b0, hop_pos_r} + 1'b1;
  assign tick_inc  = {1'b0, ticks_r} + 1'b1;
  assign timeout   = !is_packet && (mode_r == rlph_pkg::LINK_BIND) &&
                     (tick_inc > {1'b0, cfg.timeout_ticks});

  // next state of the link and its counters
  always_comb begin
    mode_nxt    = mode_r;
    known_nxt   = known_r;
    hop_pos_nxt = hop_pos_r;
    ticks_nxt   = ticks_r;
    if (is_packet) begin
      ticks_nxt = '0;
      if (hop_inc == (POS_W+1)'(PERIOD)) begin
        hop_pos_nxt = '0;
      end else begin
        hop_pos_nxt = hop_inc[POS_W-1:0];
      end
      unique case (mode_r)
        rlph_pkg::LINK_PAIR: begin
          if (pair_flag) begin
            if (transmitter_id == cfg.known_id) begin
              known_nxt = 1'b1;
              mode_nxt  = rlph_pkg::LINK_BIND;
            end else begin
              known_nxt = 1'b0;
            end
          end
        end
        rlph_pkg::LINK_BIND: begin
        end
        default: begin
          // reinit (or an unused code): restart pairing on the defaults
          known_nxt   = 1'b0;
          mode_nxt    = rlph_pkg::LINK_PAIR;
          hop_pos_nxt = '0;
        end
      endcase
    end else if (timeout) begin
      mode_nxt    = rlph_pkg::LINK_PAIR;
      known_nxt   = 1'b0;
      hop_pos_nxt = '0;
      ticks_nxt   = '0;
    end else begin
      ticks_nxt = tick_inc[rlph_pkg::TICK_W] ? '1 : tick_inc[rlph_pkg::TICK_W-1:0];
    end
  end

  // result for this item
  always_comb begin
    half_pos = hop_pos_nxt >> 1;
    slot     = 2'(half_pos);
    chan_set = known_nxt ? cfg.known_channels : cfg.default_channels;
    res.hop  = is_packet ? !hop_pos_nxt[0] : timeout;
    if (res.hop) begin
      res.channel = chan_set[{slot, 3'b000} +: rlph_pkg::CH_W];
    end else begin
      res.channel = '0;
    end
    res.disconnected = timeout;
    res.link_state   = mode_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= rlph_pkg::LINK_REINIT;
      known_r   <= 1'b0;
      hop_pos_r <= '0;
      ticks_r   <= '0;
    end else if (step_en) begin
      mode_r    <= mode_nxt;
      known_r   <= known_nxt;
      hop_pos_r <= hop_pos_nxt;
      ticks_r   <= ticks_nxt;
    end
  end

  // the known channel set is only in use while bound
  a_known_only_bound: assert property (@(posedge clk) disable iff (!rst_n)
    known_r |-> (mode_r == rlph_pkg::LINK_BIND))
    else $error("known channel set active outside bind");

  // hop counter stays inside its period
  a_hop_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, hop_pos_r} < (POS_W+1)'(PERIOD))
    else $error("hop position out of range");

  // a disconnect can only come from a bound link and always retunes
  a_disc_from_bind: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res.disconnected) |-> (mode_r == rlph_pkg::LINK_BIND && res.hop))
    else $error("disconnect outside bind or without hop");

  // a packet transfer clears the tick count
  a_packet_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && is_packet) |=> (ticks_r == '0))
    else $error("tick count not cleared by packet");

endmodule

// File: design/radio_link_pair_and_hop_fsm.sv
// Top level of the radio link pairing and frequency hopping controller.
//
// in_ch takes one item per transfer: a received packet (command packet, with
// pair_flag and transmitter_id) or one elapsed time tick. out_ch returns
// exactly one result per input item, in order: hop order, channel, disconnect
// flag and the link state after the item.
// cfg_ch writes one of the four registers (default channels, known id, known
// channels, timeout ticks) per transfer; it is always ready. The user must write
// it only while no item is in flight; the block itself does not enforce it.
// The state update and the result are computed in the cycle of the input
// transfer and the result sits in the output register from the next cycle on.
// Throughput is one item per cycle, set by the single output register:
// in_ch.ready is high whenever that register is empty or is being drained in
// the same cycle.
// When the receiver stalls, the result holds in the output register and
// in_ch.ready drops until it is taken; no state advances meanwhile.
// Reset puts the link in reinit on the default channels with all counters at
// zero and the registers at their reset values; there is no clearing pass.
`timescale 1ns / 1ps

module radio_link_pair_and_hop_fsm #(
  parameter int HOP_CHANNELS = rlph_pkg::HOP_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rlph_in_if.sink     in_ch,
  rlph_out_if.source  out_ch,
  rlph_cfg_if.sink    cfg_ch
);

  rlph_pkg::cfg_t    cfg;
  rlph_pkg::result_t res;
  rlph_pkg::result_t res_r;
  logic              out_valid_r;
  logic              in_xfer;

  // configuration registers
  rlph_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // input transfer when the output register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // link step logic
  rlph_step #(
    .HOP_CHANNELS (HOP_CHANNELS)
  ) u_step (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (in_xfer),
    .command        (in_ch.command),
    .pair_flag      (in_ch.pair_flag),
    .transmitter_id (in_ch.transmitter_id),
    .cfg            (cfg),
    .res            (res)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hop          = res_r.hop;
  assign out_ch.channel      = res_r.channel;
  assign out_ch.disconnected = res_r.disconnected;
  assign out_ch.link_state   = res_r.link_state;

endmodule

// File: verif/rlph_link_checker.sv
// checker for the radio link controller: models link state, predicts results, compares transfers
`timescale 1ns / 1ps

module rlph_link_checker
  import rlph_pkg::*;
#(
  parameter int HOP_CHANNELS = HOP_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_command,
  input  logic                  in_pair_flag,
  input  logic [ID_W-1:0]       in_transmitter_id,
  // result channel
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_hop,
  input  logic [CH_W-1:0]       out_channel,
  input  logic                  out_disconnected,
  input  logic [1:0]            out_link_state,
  // register write channel
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    outstanding
);

  localparam int HOP_PERIOD = 2 * HOP_CHANNELS;
  localparam int TICK_MAX   = (1 << TICK_W) - 1;

  // shadow registers
  logic [SET_W-1:0]  def_set;
  logic [ID_W-1:0]   own_id;
  logic [SET_W-1:0]  own_set;
  logic [TICK_W-1:0] tmo_limit;

  // modeled link state
  link_mode_t        mode_q;
  int                hop_slot;
  logic              on_own_set;
  logic [TICK_W-1:0] idle_ticks;

  // results waiting for their transfer, oldest first
  result_t expected_results[$];

  // channel byte of the active set, index wraps over the four bytes
  function automatic logic [CH_W-1:0] set_channel(input int slot);
    logic [SET_W-1:0] set;
    set = on_own_set ? own_set : def_set;
    return set[(slot % 4) * CH_W +: CH_W];
  endfunction

  // advance the link by one packet or tick and form its result
  task automatic advance_link(input logic cmd, input logic pflag, input logic [ID_W-1:0] id,
                              output result_t res);
    logic restart;
    int   nxt;
    res = '0;
    if (cmd == CMD_PACKET) begin
      restart = 1'b0;
      idle_ticks = '0;
      if (mode_q == LINK_PAIR) begin
        if (pflag) begin
          if (id == own_id) begin
            on_own_set = 1'b1;
            mode_q = LINK_BIND;
          end else begin
            on_own_set = 1'b0;
          end
        end
      end else if (mode_q != LINK_BIND) begin
        on_own_set = 1'b0;
        mode_q = LINK_PAIR;
        restart = 1'b1;
      end
      hop_slot = restart ? 0 : (hop_slot + 1) % HOP_PERIOD;
      if (hop_slot % 2 == 0) begin
        res.hop = 1'b1;
        res.channel = set_channel(hop_slot / 2);
      end
    end else begin
      nxt = int'(idle_ticks) + 1;
      idle_ticks = (nxt > TICK_MAX) ? TICK_W'(TICK_MAX) : TICK_W'(nxt);
      // bind timeout compares the unsaturated count
      if (mode_q == LINK_BIND && nxt > int'(tmo_limit)) begin
        res.disconnected = 1'b1;
        mode_q = LINK_PAIR;
        on_own_set = 1'b0;
        hop_slot = 0;
        idle_ticks = '0;
        res.hop = 1'b1;
        res.channel = set_channel(0);
      end
    end
    res.link_state = mode_q;
  endtask

  // watch the three channels at each rising edge
  always @(posedge clk) begin
    result_t want;
    result_t pred;
    int      errs;
    errs = 0;
    if (!rst_n) begin
      def_set     = DEFAULT_CHANNELS_RST;
      own_id      = KNOWN_ID_RST;
      own_set     = KNOWN_CHANNELS_RST;
      tmo_limit   = TIMEOUT_TICKS_RST;
      mode_q      = LINK_REINIT;
      hop_slot    = 0;
      on_own_set  = 1'b0;
      idle_ticks  = '0;
      expected_results.delete();
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_DEFAULT_CHANNELS: def_set   = cfg_data[SET_W-1:0];
          CFG_KNOWN_ID:         own_id    = cfg_data[ID_W-1:0];
          CFG_KNOWN_CHANNELS:   own_set   = cfg_data[SET_W-1:0];
          CFG_TIMEOUT_TICKS:    tmo_limit = cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      // result transfer against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: hop %0d channel %0d disconnected %0d link_state %0d",
                 out_hop, out_channel, out_disconnected, out_link_state);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (out_hop !== want.hop) begin
            $error("hop: expected %0d, actual %0d", want.hop, out_hop);
            errs++;
          end
          if (out_channel !== want.channel) begin
            $error("channel: expected %0d, actual %0d", want.channel, out_channel);
            errs++;
          end
          if (out_disconnected !== want.disconnected) begin
            $error("disconnected: expected %0d, actual %0d", want.disconnected,
                   out_disconnected);
            errs++;
          end
          if (out_link_state !== want.link_state) begin
            $error("link_state: expected %0d, actual %0d", want.link_state, out_link_state);
            errs++;
          end
        end
      end
      // input transfer
      if (in_valid && in_ready) begin
        advance_link(in_command, in_pair_flag, in_transmitter_id, pred);
        expected_results.push_back(pred);
      end
      fail_count  <= fail_count + errs;
      outstanding <= expected_results.size();
    end
  end

endmodule

// File: verif/radio_link_pair_and_hop_fsm_tb.sv
// testbench top for the radio link controller: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module radio_link_pair_and_hop_fsm_tb;
  import rlph_pkg::*;

  localparam int HOP_CHANNELS = HOP_CHANNELS_DEF;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 4;
  localparam int IDLE_PCT     = 27;
  localparam int TICK_MAX     = (1 << TICK_W) - 1;

  logic clk;
  logic rst_n;

  // traffic shaping shared by sender and receiver
  logic idle_on;
  int   hold_requests;
  int   holds_served;

  // current known id and timeout register values as written
  logic [ID_W-1:0]   cur_kid;
  logic [TICK_W-1:0] cur_tmo;

  int fail_count;
  int outstanding;

  rlph_in_if  in_ch ();
  rlph_out_if out_ch ();
  rlph_cfg_if cfg_ch ();

  radio_link_pair_and_hop_fsm #(
    .HOP_CHANNELS (HOP_CHANNELS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rlph_link_checker #(
    .HOP_CHANNELS (HOP_CHANNELS)
  ) i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_command        (in_ch.command),
    .in_pair_flag      (in_ch.pair_flag),
    .in_transmitter_id (in_ch.transmitter_id),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_hop           (out_ch.hop),
    .out_channel       (out_ch.channel),
    .out_disconnected  (out_ch.disconnected),
    .out_link_state    (out_ch.link_state),
    .cfg_valid         (cfg_ch.valid),
    .cfg_ready         (cfg_ch.ready),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .fail_count        (fail_count),
    .outstanding       (outstanding)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result receiver with random stalls and requested long hold-offs
  initial begin
    out_ch.ready = 1'b0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_served++;
      end else begin
        out_ch.ready = !idle_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // one input transfer, called just after a falling edge
  task automatic send_item(input logic cmd, input logic pflag, input logic [ID_W-1:0] id);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.command        = cmd;
    in_ch.pair_flag      = pflag;
    in_ch.transmitter_id = id;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // tick with random don't-care fields
  task automatic send_tick();
    send_item(CMD_TICK, 1'($urandom), ID_W'($urandom));
  endtask

  // wait until every predicted result has been taken
  task automatic drain();
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one register write transfer
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // timeout change only, with the link idle
  task automatic set_timeout(input logic [TICK_W-1:0] tmo);
    drain();
    write_reg(CFG_TIMEOUT_TICKS, CFG_DATA_W'(tmo));
    cur_tmo = tmo;
  endtask

  // full register setup, with the link idle
  task automatic load_link_setup(input logic [SET_W-1:0] dch, input logic [ID_W-1:0] kid,
                                 input logic [SET_W-1:0] kch, input logic [TICK_W-1:0] tmo);
    drain();
    write_reg(CFG_DEFAULT_CHANNELS, dch);
    write_reg(CFG_KNOWN_ID, CFG_DATA_W'(kid));
    write_reg(CFG_KNOWN_CHANNELS, kch);
    write_reg(CFG_TIMEOUT_TICKS, CFG_DATA_W'(tmo));
    cur_kid = kid;
    cur_tmo = tmo;
  endtask

  // random mix of bind attempts, hopping packets, tick runs and noise
  task automatic random_traffic(input int n_items);
    int sent;
    int kind;
    int run_len;
    int run_max;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(9);
      if (kind <= 2) begin
        send_item(CMD_PACKET, 1'($urandom), ID_W'($urandom));
        sent++;
      end else if (kind <= 4) begin
        send_item(CMD_PACKET, 1'b1, cur_kid);
        sent++;
      end else if (kind <= 7) begin
        run_max = int'(cur_tmo) + 2;
        if (run_max > 64) run_max = 64;
        run_len = $urandom_range(1, run_max);
        repeat (run_len) send_tick();
        sent += run_len;
      end else if (kind == 8) begin
        send_item(CMD_PACKET, 1'b0, cur_kid);
        sent++;
      end else begin
        // near miss on the known id
        send_item(CMD_PACKET, 1'b1, cur_kid ^ (ID_W'(1) << $urandom_range(ID_W - 1)));
        sent++;
      end
    end
  endtask

  // pick a timeout, mostly short so that disconnects happen often
  function automatic logic [TICK_W-1:0] pick_timeout();
    if ($urandom_range(3) == 0) return TICK_W'($urandom_range(13, 60));
    return TICK_W'($urandom_range(1, 12));
  endfunction

  // stimulus and verdict
  initial begin
    logic [SET_W-1:0]  dch;
    logic [ID_W-1:0]   kid;
    logic [SET_W-1:0]  kch;
    logic [TICK_W-1:0] tmo;
    rst_n                = 1'b0;
    idle_on              = 1'b1;
    hold_requests        = 0;
    cur_kid              = KNOWN_ID_RST;
    cur_tmo              = TIMEOUT_TICKS_RST;
    in_ch.valid          = 1'b0;
    in_ch.command        = CMD_PACKET;
    in_ch.pair_flag      = 1'b0;
    in_ch.transmitter_id = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = CFG_DEFAULT_CHANNELS;
    cfg_ch.data          = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset registers, pairing, binding and hop wrap
    send_tick();
    send_item(CMD_PACKET, 1'b1, KNOWN_ID_RST);
    send_item(CMD_PACKET, 1'b0, KNOWN_ID_RST);
    send_item(CMD_PACKET, 1'b1, '0);
    send_item(CMD_PACKET, 1'b1, '1);
    send_item(CMD_PACKET, 1'b1, KNOWN_ID_RST);
    repeat (4) send_item(CMD_PACKET, 1'b0, ID_W'($urandom));
    send_item(CMD_PACKET, 1'b1, '1);

    // directed: bind timeout, then a tick while pairing
    set_timeout(TICK_W'(2));
    repeat (4) send_tick();

    // directed: zero timeout expires on the first tick
    set_timeout('0);
    send_item(CMD_PACKET, 1'b1, cur_kid);
    send_tick();

    // directed: timeout of one tick, a packet restarts the count
    set_timeout(TICK_W'(1));
    send_item(CMD_PACKET, 1'b1, cur_kid);
    send_tick();
    send_item(CMD_PACKET, 1'b0, '0);
    send_tick();
    send_tick();

    // random phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      dch = $urandom;
      kid = ID_W'($urandom);
      kch = $urandom;
      tmo = pick_timeout();
      case (ph)
        0: dch = '0;
        1: begin dch = '1; kch = '0; end
        2: kid = '0;
        3: kid = '1;
        4: tmo = TICK_W'(1);
        5: begin tmo = TICK_W'(TICK_MAX); kch = '1; end
        default: ;
      endcase
      load_link_setup(dch, kid, kch, tmo);
      idle_on = (ph != 6);
      if (ph == 3) begin
        // receiver holds off while the sender keeps offering
        random_traffic(20);
        hold_requests++;
        random_traffic(185);
      end else begin
        random_traffic(205);
      end
    end
    idle_on = 1'b1;

    drain();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/rlph_pkg.sv
design/rlph_in_if.sv
design/rlph_out_if.sv
design/rlph_cfg_if.sv
design/rlph_cfg_regs.sv
design/rlph_step.sv
design/radio_link_pair_and_hop_fsm.sv
verif/rlph_link_checker.sv
verif/radio_link_pair_and_hop_fsm_tb.sv
